FILE: hw/rtl/dkw_pkg.sv
// Shared types, constants and helpers of the distance kernel weight core.
package dkw_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int EXP_DEPTH_DEF   = 256;
    localparam int OUT_FRAC        = 16;
    localparam int TBL_FRAC        = 30;
    localparam int SER_FRAC        = 48;
    localparam int SER_TERMS       = 24;
    localparam int EXP_INT_LIMIT   = 12;
    localparam int CFG_IDX_W       = 8;
    localparam int BW_RESET        = 65536;

    localparam logic [CFG_IDX_W-1:0] REG_KIND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BW   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        KIND_BISQUARE = 2'd0,
        KIND_GAUSSIAN = 2'd1,
        KIND_TRICUBE  = 2'd2,
        KIND_EXPON    = 2'd3
    } kernel_kind_t;

    typedef struct packed {
        logic valid;
        logic le;
        logic ovf;
    } div_flags_t;

    // round to nearest, then shift right
    function automatic logic [63:0] rnd_sh(logic [63:0] x, int s);
        logic [63:0] half;
        half = (s == 0) ? 64'd0 : (64'd1 << (s - 1));
        return (x + half) >> s;
    endfunction

endpackage

FILE: hw/rtl/distance_kernel_weight_core.sv
// Top level of the distance kernel weight core: configuration and pipeline.
//
//  channel   direction  transfer when         payload
//  s_        in         s_valid & s_ready     s_distance  [31:0] Q16.16
//  m_        out        m_valid & m_ready     m_weight    [16:0] Q1.16
//  cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// One distance per cycle while not stalled; FRAC_BITS+6 divider stages plus 9 kernel stages.
// The divider retires one quotient bit per stage; kernel multiplies sit in every other stage.
// Reset clears the valid bits and loads kind bisquare, bandwidth 1.0.
// When m_valid is high and m_ready low the whole pipeline holds; s_ready drops with it.
module distance_kernel_weight_core import dkw_pkg::*; #(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_distance,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [16:0]          m_weight,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);
    kernel_kind_t         kind_reg;
    logic [31:0]          bw_reg;
    logic                 en;
    div_flags_t           flags;
    logic [FRAC_BITS+4:0] quot;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_BISQUARE;
            bw_reg   <= 32'(BW_RESET);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_KIND) kind_reg <= kernel_kind_t'(cfg_wdata[1:0]);
            if (cfg_index == REG_BW)   bw_reg   <= cfg_wdata;
        end
    end

    dkw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .distance  (s_distance),
        .bandwidth (bw_reg),
        .flags     (flags),
        .quot      (quot)
    );

    dkw_kernel #(.FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .kind      (kind_reg),
        .flags     (flags),
        .quot      (quot),
        .out_valid (m_valid),
        .weight    (m_weight)
    );

`ifndef SYNTHESIS
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_weight <= 17'd65536)
        else $error("weight above 1.0");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_weight))
        else $error("result lost during stall");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result right after reset");
`endif

endmodule

FILE: hw/rtl/dkw_div.sv
// Pipelined restoring divider forming the rounded ratio distance / bandwidth.
module dkw_div import dkw_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [31:0]          distance,
    input  logic [31:0]          bandwidth,
    output div_flags_t           flags,
    output logic [FRAC_BITS+4:0] quot
);
    localparam int RW = FRAC_BITS + 5;
    localparam int NW = 32 + FRAC_BITS + 1;

    logic [31:0]    bwe;
    logic [NW-1:0]  num;
    logic           ovf;

    logic [31:0]    rem_reg  [0:RW];
    logic [RW-1:0]  nlo_reg  [0:RW];
    logic [RW-1:0]  q_reg    [0:RW];
    div_flags_t     flg_reg  [0:RW];

    assign bwe = (bandwidth == 32'd0) ? 32'd1 : bandwidth;
    assign num = {1'b0, distance, {FRAC_BITS{1'b0}}} + NW'(bwe[31:1]);
    assign ovf = 32'(num >> RW) >= bwe;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flg_reg[0] <= '0;
        end else if (en) begin
            flg_reg[0] <= '{valid: in_valid, le: distance <= bwe, ovf: ovf};
        end
        if (en) begin
            rem_reg[0] <= ovf ? 32'd0 : 32'(num >> RW);
            nlo_reg[0] <= num[RW-1:0];
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_step
        logic [32:0] trial;
        logic        ge;
        assign trial = {rem_reg[k-1], nlo_reg[k-1][RW-1]};
        assign ge    = trial >= {1'b0, bwe};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                flg_reg[k] <= '0;
            end else if (en) begin
                flg_reg[k] <= flg_reg[k-1];
            end
            if (en) begin
                rem_reg[k] <= ge ? 32'(trial - {1'b0, bwe}) : trial[31:0];
                nlo_reg[k] <= nlo_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][RW-2:0], ge};
            end
        end
    end

    assign flags = flg_reg[RW];
    assign quot  = q_reg[RW];

endmodule

FILE: hw/rtl/dkw_kernel.sv
// Kernel evaluation pipeline: polynomial kernels and interpolated exponentials.
module dkw_kernel import dkw_pkg::*; #(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  kernel_kind_t         kind,
    input  div_flags_t           flags,
    input  logic [FRAC_BITS+4:0] quot,
    output logic                 out_valid,
    output logic [16:0]          weight
);
    localparam int F   = FRAC_BITS;
    localparam int RW  = F + 5;
    localparam int XW  = F + 8;
    localparam int IW  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PW1 = 2 * F + 14;
    localparam int PW2 = 31 + F;
    localparam int WSH = 2 * F - OUT_FRAC;
    localparam int ESH = 2 * TBL_FRAC - OUT_FRAC;
    localparam logic [F:0]    ONE    = (F+1)'(1) << F;
    localparam logic [RW-1:0] R_SAT  = RW'(16) << F;

    function automatic logic [30:0] frac_val(int j);
        logic [63:0] term, ev, od;
        term = 64'd1 << SER_FRAC;
        ev   = term;
        od   = 64'd0;
        for (int k = 1; k <= SER_TERMS; k++) begin
            term = term * 64'(j) / 64'(EXP_TABLE_DEPTH * k);
            if (k % 2 == 1) od = od + term;
            else            ev = ev + term;
        end
        return 31'(rnd_sh((ev >= od) ? ev - od : 64'd0, SER_FRAC - TBL_FRAC));
    endfunction

    function automatic logic [30:0] int_val(int n);
        logic [63:0] p;
        p = 64'd1 << TBL_FRAC;
        for (int k = 1; k <= n; k++) begin
            p = rnd_sh(p * 64'(frac_val(EXP_TABLE_DEPTH)), TBL_FRAC);
        end
        return 31'(p);
    endfunction

    logic [30:0] tbl_frac [0:EXP_TABLE_DEPTH];
    logic [30:0] tbl_int  [0:EXP_INT_LIMIT-1];

    for (genvar j = 0; j <= EXP_TABLE_DEPTH; j++) begin : g_tf
        assign tbl_frac[j] = frac_val(j);
    end
    for (genvar n = 0; n < EXP_INT_LIMIT; n++) begin : g_ti
        assign tbl_int[n] = int_val(n);
    end

    logic          is_exp;
    assign is_exp = (kind == KIND_GAUSSIAN) || (kind == KIND_EXPON);

    // stage registers
    logic [8:0]       vld_reg;
    logic [RW-1:0]    a_r_reg;
    logic             a_zero_reg;
    logic [2*RW-1:0]  b_sq_reg;
    logic [RW-1:0]    b_r_reg;
    logic             b_zero_reg;
    logic [F:0]       c_t_reg, c_r2_reg, c_r_reg;
    logic [XW-1:0]    c_x_reg;
    logic             c_zero_reg;
    logic [PW1-1:0]   d_prod_reg;
    logic [XW-F-1:0]  d_n_reg;
    logic             d_zero_reg;
    logic [16:0]      e_w_reg;
    logic [F:0]       e_t_reg;
    logic [30:0]      e_a_reg, e_diff_reg;
    logic [F-1:0]     e_g_reg;
    logic [3:0]       e_n_reg;
    logic             e_zero_reg;
    logic [PW2-1:0]   f_prod_reg;
    logic [16:0]      f_w_reg;
    logic [F:0]       f_t_reg;
    logic [30:0]      f_a_reg;
    logic [3:0]       f_n_reg;
    logic             f_zero_reg;
    logic [30:0]      g_val_reg;
    logic [16:0]      g_w_reg;
    logic [F:0]       g_t_reg;
    logic [3:0]       g_n_reg;
    logic             g_zero_reg;
    logic [61:0]      h_prod_reg;
    logic [16:0]      h_w_reg;
    logic             h_zero_reg;
    logic [16:0]      w_reg;

    // combinational per stage
    logic [RW-1:0]   a_r_next;
    logic            a_zero_next;
    logic [F:0]      c_r2_next;
    logic [XW-1:0]   c_x_next;
    logic [PW1-1:0]  d_prod_next;
    logic [IW-1:0]   e_idx, e_idx1;
    logic [30:0]     e_ta, e_tb;
    logic [F:0]      e_r3;
    logic [PW2-1:0]  f_prod_next;
    logic [30:0]     g_val_next;
    logic [61:0]     h_prod_next;
    logic [16:0]     w_next;

    always_comb begin
        a_zero_next = 1'b0;
        if (is_exp) begin
            a_r_next = (flags.ovf || quot > R_SAT) ? R_SAT : quot;
        end else begin
            a_zero_next = !flags.le;
            a_r_next    = (quot > RW'(ONE)) ? RW'(ONE) : quot;
        end
    end

    assign c_r2_next = (F+1)'(rnd_sh(64'(b_sq_reg), F));
    assign c_x_next  = (kind == KIND_GAUSSIAN) ? XW'(rnd_sh(64'(b_sq_reg), F + 1))
                                               : XW'(b_r_reg);

    always_comb begin
        unique case (kind)
            KIND_BISQUARE: d_prod_next = PW1'(c_t_reg * c_t_reg);
            KIND_TRICUBE:  d_prod_next = PW1'(c_r2_reg * c_r_reg);
            default:       d_prod_next = PW1'(c_x_reg[F-1:0] * IW'(EXP_TABLE_DEPTH));
        endcase
    end

    assign e_idx  = d_prod_reg[F+IW-1:F];
    assign e_idx1 = e_idx + IW'(1);
    assign e_ta   = tbl_frac[e_idx];
    assign e_tb   = tbl_frac[e_idx1];
    assign e_r3   = (F+1)'(rnd_sh(64'(d_prod_reg), F));

    assign f_prod_next = (kind == KIND_TRICUBE) ? PW2'(e_t_reg * e_t_reg)
                                                : PW2'(e_diff_reg * e_g_reg);

    assign g_val_next = (kind == KIND_TRICUBE) ? 31'(rnd_sh(64'(f_prod_reg), F))
                      : 31'(f_a_reg - 31'(rnd_sh(64'(f_prod_reg), F)));

    assign h_prod_next = (kind == KIND_TRICUBE) ? 62'(g_val_reg * g_t_reg)
                                                : 62'(g_val_reg * tbl_int[g_n_reg]);

    always_comb begin
        unique case (kind)
            KIND_BISQUARE: w_next = h_w_reg;
            KIND_TRICUBE:  w_next = 17'(rnd_sh(64'(h_prod_reg), WSH));
            default:       w_next = 17'(rnd_sh(64'(h_prod_reg), ESH));
        endcase
        if (h_zero_reg) w_next = 17'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[7:0], flags.valid};
        end
        if (en) begin
            a_r_reg    <= a_r_next;
            a_zero_reg <= a_zero_next;

            b_sq_reg   <= a_r_reg * a_r_reg;
            b_r_reg    <= a_r_reg;
            b_zero_reg <= a_zero_reg;

            c_r2_reg   <= c_r2_next;
            c_t_reg    <= ONE - c_r2_next;
            c_r_reg    <= b_r_reg[F:0];
            c_x_reg    <= c_x_next;
            c_zero_reg <= b_zero_reg;

            d_prod_reg <= d_prod_next;
            d_n_reg    <= c_x_reg[XW-1:F];
            d_zero_reg <= c_zero_reg || (is_exp && c_x_reg[XW-1:F] >= (XW-F)'(EXP_INT_LIMIT));

            e_w_reg    <= 17'(rnd_sh(64'(d_prod_reg), WSH));
            e_t_reg    <= ONE - e_r3;
            e_a_reg    <= e_ta;
            e_diff_reg <= (e_ta >= e_tb) ? e_ta - e_tb : 31'd0;
            e_g_reg    <= d_prod_reg[F-1:0];
            e_n_reg    <= d_n_reg[3:0];
            e_zero_reg <= d_zero_reg;

            f_prod_reg <= f_prod_next;
            f_w_reg    <= e_w_reg;
            f_t_reg    <= e_t_reg;
            f_a_reg    <= e_a_reg;
            f_n_reg    <= e_n_reg;
            f_zero_reg <= e_zero_reg;

            g_val_reg  <= g_val_next;
            g_w_reg    <= f_w_reg;
            g_t_reg    <= f_t_reg;
            g_n_reg    <= f_n_reg;
            g_zero_reg <= f_zero_reg;

            h_prod_reg <= h_prod_next;
            h_w_reg    <= g_w_reg;
            h_zero_reg <= g_zero_reg;

            w_reg      <= w_next;
        end
    end

    assign out_valid = vld_reg[8];
    assign weight    = w_reg;

endmodule
